// ----- design/hfa_pkg.sv -----
// Shared constants, types and state encodings for the hole-fit allocator.
// No dependencies; every other design file imports this package.
package hfa_pkg;

    localparam int MAX_HOLES   = 16;
    localparam int SIZE_BITS   = 16;
    localparam int HOLE_BITS   = $clog2(MAX_HOLES);
    localparam int CNT_BITS    = $clog2(MAX_HOLES + 1);
    localparam int HC_BITS     = 5;
    localparam int POLICY_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [0:0] REG_FIT_POLICY = 1'b0;
    localparam logic [0:0] REG_HOLE_COUNT = 1'b1;

    localparam logic [HC_BITS-1:0] HOLE_COUNT_RESET = HC_BITS'(MAX_HOLES);

    typedef enum logic [POLICY_BITS-1:0] {
        FIT_FIRST,
        FIT_BEST,
        FIT_WORST,
        FIT_NEXT
    } t_fit_policy;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_GRANTED,
        ST_NO_FIT,
        ST_REFUSED,
        ST_LOAD_DONE
    } t_status;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_WRITE,
        SQ_PEAK,
        SQ_EMIT
    } t_seq_state;

    typedef struct packed {
        logic                 en;
        logic [HOLE_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] free_size;
        logic [SIZE_BITS-1:0] used_size;
    } t_store_wr;

endpackage

// ----- design/hfa_ifs.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on hfa_pkg for field widths.
interface hfa_in_if import hfa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [HOLE_BITS-1:0] hole_index;
    logic [SIZE_BITS-1:0] amount;
    logic                 last_request;

    modport source (output valid, mode, hole_index, amount, last_request, input ready);
    modport sink   (input valid, mode, hole_index, amount, last_request, output ready);
endinterface

interface hfa_out_if import hfa_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [HOLE_BITS-1:0]   chosen_hole;
    logic [SIZE_BITS-1:0]   hole_left;
    logic [SIZE_BITS-1:0]   hole_used;
    logic [SIZE_BITS-1:0]   largest_left;
    logic                   run_failed;

    modport source (output valid, status, chosen_hole, hole_left, hole_used, largest_left,
                    run_failed, input ready);
    modport sink   (input valid, status, chosen_hole, hole_left, hole_used, largest_left,
                    run_failed, output ready);
endinterface

// ----- design/hfa_store.sv -----
// Hole table: free-size and used-total memories, one write and one registered read port.
// Used totals read as zero until written (per-entry valid bits). Depends on hfa_pkg.
module hfa_store import hfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_store_wr            i_wr,
    input  logic [HOLE_BITS-1:0] i_rd_addr,
    output logic [SIZE_BITS-1:0] o_rd_free,
    output logic [SIZE_BITS-1:0] o_rd_used
);

    logic [SIZE_BITS-1:0] r_free_mem [MAX_HOLES];
    logic [SIZE_BITS-1:0] r_used_mem [MAX_HOLES];
    logic [MAX_HOLES-1:0] r_used_vld;
    logic [SIZE_BITS-1:0] r_rd_free;
    logic [SIZE_BITS-1:0] r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_free_mem[i_wr.addr] <= i_wr.free_size;
            r_used_mem[i_wr.addr] <= i_wr.used_size;
        end
        r_rd_free <= r_free_mem[i_rd_addr];
        r_rd_used <= r_used_vld[i_rd_addr] ? r_used_mem[i_rd_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_vld <= '0;
        end else if (i_wr.en) begin
            r_used_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_free = r_rd_free;
    assign o_rd_used = r_rd_used;

endmodule

// ----- design/hole_fit_allocator.sv -----
// Hole-fit allocator top level: APB registers, scan sequencer, shared compare unit.
// Depends on hfa_pkg, hfa_ifs (hfa_in_if, hfa_out_if) and hfa_store.
//
//  channel   dir  handshake            payload
//  i_req     in   valid/ready          mode, hole_index, amount, last_request
//  o_rsp     out  valid/ready          status, chosen_hole, hole_left, hole_used,
//                                      largest_left, run_failed
//  apb       in   psel/penable/pready  paddr, pwdata, prdata (fit_policy @0, hole_count @4)
//
// Load and refused beats go from IDLE to EMIT, then into the output register. Allocate:
// one table read per hole through the single read port (n = holes in use), then
// n reads for the largest-hole pass when last_request is set. First and next fit stop
// at the first fitting hole. A finished response waits in the output register while
// the next beat is accepted; the sequencer stalls only if that register is still full.
// Reset is synchronous active low; the used totals read as zero after reset.
module hole_fit_allocator import hfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hfa_in_if.sink            i_req,
    hfa_out_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_seq_state  r_state, n_state;
    t_fit_policy r_fit_policy;
    logic [HC_BITS-1:0] r_hole_count;

    logic                 r_failed, n_failed;
    logic [HOLE_BITS-1:0] r_next_ptr, n_next_ptr;
    logic [SIZE_BITS-1:0] r_amount, n_amount;
    logic                 r_last, n_last;

    logic [HOLE_BITS-1:0] r_iss_addr, n_iss_addr;
    logic [CNT_BITS-1:0]  r_iss_cnt, n_iss_cnt;
    logic                 r_chk_vld, n_chk_vld;
    logic [HOLE_BITS-1:0] r_chk_addr, n_chk_addr;
    logic                 r_pick_vld, n_pick_vld;
    logic [HOLE_BITS-1:0] r_pick_addr, n_pick_addr;
    logic [SIZE_BITS-1:0] r_pick_free, n_pick_free;
    logic [SIZE_BITS-1:0] r_pick_used, n_pick_used;
    logic [SIZE_BITS-1:0] r_peak, n_peak;

    t_status              r_res_status, n_res_status;
    logic [HOLE_BITS-1:0] r_res_hole, n_res_hole;
    logic [SIZE_BITS-1:0] r_res_left, n_res_left;
    logic [SIZE_BITS-1:0] r_res_used, n_res_used;
    logic [SIZE_BITS-1:0] r_res_largest, n_res_largest;

    logic                 r_out_vld, n_out_vld;
    t_status              r_out_status, n_out_status;
    logic [HOLE_BITS-1:0] r_out_hole, n_out_hole;
    logic [SIZE_BITS-1:0] r_out_left, n_out_left;
    logic [SIZE_BITS-1:0] r_out_used, n_out_used;
    logic [SIZE_BITS-1:0] r_out_largest, n_out_largest;
    logic                 r_out_failed, n_out_failed;

    t_store_wr            store_wr;
    logic [HOLE_BITS-1:0] rd_addr;
    logic [SIZE_BITS-1:0] rd_free;
    logic [SIZE_BITS-1:0] rd_used;

    logic [CNT_BITS-1:0]  holes_n;
    logic [HOLE_BITS-1:0] start_addr;
    logic [CNT_BITS-1:0]  iss_inc;
    logic                 issue;
    logic                 req_ready;
    logic                 req_take;
    logic                 cfg_wr;

    logic [SIZE_BITS-1:0] cmp_ref;
    logic                 fit;
    logic                 cmp_gt;
    logic                 cmp_lt;
    logic                 take;
    logic                 stop_first;
    logic [SIZE_BITS:0]   used_sum;
    logic [SIZE_BITS-1:0] peak_new;

    hfa_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_addr (rd_addr),
        .o_rd_free (rd_free),
        .o_rd_used (rd_used)
    );

    // APB registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy <= FIT_FIRST;
            r_hole_count <= HOLE_COUNT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FIT_POLICY: r_fit_policy <= t_fit_policy'(pwdata[POLICY_BITS-1:0]);
                REG_HOLE_COUNT: r_hole_count <= pwdata[HC_BITS-1:0];
                default:        r_hole_count <= r_hole_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIT_POLICY: prdata = APB_DW'(r_fit_policy);
            REG_HOLE_COUNT: prdata = APB_DW'(r_hole_count);
            default:        prdata = '0;
        endcase
    end

    // holes in use, scan start and circular step
    always_comb begin
        if (r_hole_count == '0) begin
            holes_n = CNT_BITS'(1);
        end else if (r_hole_count > HC_BITS'(MAX_HOLES)) begin
            holes_n = CNT_BITS'(MAX_HOLES);
        end else begin
            holes_n = CNT_BITS'(r_hole_count);
        end
    end

    assign start_addr = (r_fit_policy == FIT_NEXT && CNT_BITS'(r_next_ptr) < holes_n)
                        ? r_next_ptr : '0;
    assign iss_inc    = CNT_BITS'(r_iss_addr) + CNT_BITS'(1);
    assign issue      = r_iss_cnt < holes_n;
    assign rd_addr    = r_iss_addr;

    // shared compare unit
    assign cmp_ref    = (r_state == SQ_PEAK) ? r_peak : r_pick_free;
    assign fit        = r_amount <= rd_free;
    assign cmp_gt     = rd_free > cmp_ref;
    assign cmp_lt     = rd_free < cmp_ref;
    assign stop_first = r_fit_policy == FIT_FIRST || r_fit_policy == FIT_NEXT;
    assign take       = fit && (!r_pick_vld
                                || (r_fit_policy == FIT_BEST && cmp_lt)
                                || (r_fit_policy == FIT_WORST && cmp_gt));
    assign used_sum   = {1'b0, r_pick_used} + {1'b0, r_amount};
    assign peak_new   = (r_chk_vld && cmp_gt) ? rd_free : r_peak;

    assign req_ready  = r_state == SQ_IDLE;
    assign req_take   = req_ready && i_req.valid;

    always_comb begin
        n_state       = r_state;
        n_failed      = r_failed;
        n_next_ptr    = r_next_ptr;
        n_amount      = r_amount;
        n_last        = r_last;
        n_iss_addr    = r_iss_addr;
        n_iss_cnt     = r_iss_cnt;
        n_chk_vld     = r_chk_vld;
        n_chk_addr    = r_chk_addr;
        n_pick_vld    = r_pick_vld;
        n_pick_addr   = r_pick_addr;
        n_pick_free   = r_pick_free;
        n_pick_used   = r_pick_used;
        n_peak        = r_peak;
        n_res_status  = r_res_status;
        n_res_hole    = r_res_hole;
        n_res_left    = r_res_left;
        n_res_used    = r_res_used;
        n_res_largest = r_res_largest;
        n_out_vld     = r_out_vld && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_hole    = r_out_hole;
        n_out_left    = r_out_left;
        n_out_used    = r_out_used;
        n_out_largest = r_out_largest;
        n_out_failed  = r_out_failed;
        store_wr      = '0;

        case (r_state)
            SQ_IDLE: begin
                if (req_take) begin
                    n_amount      = i_req.amount;
                    n_last        = i_req.last_request;
                    n_res_hole    = '0;
                    n_res_left    = '0;
                    n_res_used    = '0;
                    n_res_largest = '0;
                    if (!i_req.mode) begin
                        store_wr.en        = 1'b1;
                        store_wr.addr      = i_req.hole_index;
                        store_wr.free_size = i_req.amount;
                        store_wr.used_size = '0;
                        n_next_ptr   = '0;
                        n_failed     = 1'b0;
                        n_res_status = ST_LOAD_DONE;
                        n_res_hole   = i_req.hole_index;
                        n_res_left   = i_req.amount;
                        n_state      = SQ_EMIT;
                    end else if (r_failed) begin
                        n_res_status = ST_REFUSED;
                        n_state      = SQ_EMIT;
                    end else begin
                        n_iss_addr = start_addr;
                        n_iss_cnt  = '0;
                        n_chk_vld  = 1'b0;
                        n_pick_vld = 1'b0;
                        n_state    = SQ_SCAN;
                    end
                end
            end
            SQ_SCAN: begin
                if (issue) begin
                    n_iss_cnt  = r_iss_cnt + CNT_BITS'(1);
                    n_iss_addr = (iss_inc < holes_n) ? iss_inc[HOLE_BITS-1:0] : '0;
                end
                n_chk_vld  = issue;
                n_chk_addr = r_iss_addr;
                if (r_chk_vld && take) begin
                    n_pick_vld  = 1'b1;
                    n_pick_addr = r_chk_addr;
                    n_pick_free = rd_free;
                    n_pick_used = rd_used;
                end
                if (r_chk_vld && take && stop_first) begin
                    n_state = SQ_WRITE;
                end else if (r_chk_vld && !issue) begin
                    if (take || r_pick_vld) begin
                        n_state = SQ_WRITE;
                    end else begin
                        n_failed     = 1'b1;
                        n_res_status = ST_NO_FIT;
                        n_state      = SQ_EMIT;
                    end
                end
            end
            SQ_WRITE: begin
                store_wr.en        = 1'b1;
                store_wr.addr      = r_pick_addr;
                store_wr.free_size = r_pick_free - r_amount;
                store_wr.used_size = used_sum[SIZE_BITS] ? '1 : used_sum[SIZE_BITS-1:0];
                if (r_fit_policy == FIT_NEXT) begin
                    n_next_ptr = r_pick_addr;
                end
                n_res_status  = ST_GRANTED;
                n_res_hole    = r_pick_addr;
                n_res_left    = store_wr.free_size;
                n_res_used    = store_wr.used_size;
                n_res_largest = '0;
                if (r_last) begin
                    n_iss_addr = '0;
                    n_iss_cnt  = '0;
                    n_chk_vld  = 1'b0;
                    n_peak     = '0;
                    n_state    = SQ_PEAK;
                end else begin
                    n_state = SQ_EMIT;
                end
            end
            SQ_PEAK: begin
                if (issue) begin
                    n_iss_cnt  = r_iss_cnt + CNT_BITS'(1);
                    n_iss_addr = (iss_inc < holes_n) ? iss_inc[HOLE_BITS-1:0] : '0;
                end
                n_chk_vld = issue;
                n_peak    = peak_new;
                if (r_chk_vld && !issue) begin
                    n_res_largest = peak_new;
                    n_state       = SQ_EMIT;
                end
            end
            SQ_EMIT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld     = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_hole    = r_res_hole;
                    n_out_left    = r_res_left;
                    n_out_used    = r_res_used;
                    n_out_largest = r_res_largest;
                    n_out_failed  = r_failed;
                    n_state       = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed   <= 1'b0;
            r_next_ptr <= '0;
            r_out_vld  <= 1'b0;
            r_iss_cnt  <= '0;
            r_chk_vld  <= 1'b0;
            r_pick_vld <= 1'b0;
        end else begin
            r_failed   <= n_failed;
            r_next_ptr <= n_next_ptr;
            r_out_vld  <= n_out_vld;
            r_iss_cnt  <= n_iss_cnt;
            r_chk_vld  <= n_chk_vld;
            r_pick_vld <= n_pick_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amount      <= n_amount;
        r_last        <= n_last;
        r_iss_addr    <= n_iss_addr;
        r_chk_addr    <= n_chk_addr;
        r_pick_addr   <= n_pick_addr;
        r_pick_free   <= n_pick_free;
        r_pick_used   <= n_pick_used;
        r_peak        <= n_peak;
        r_res_status  <= n_res_status;
        r_res_hole    <= n_res_hole;
        r_res_left    <= n_res_left;
        r_res_used    <= n_res_used;
        r_res_largest <= n_res_largest;
        r_out_status  <= n_out_status;
        r_out_hole    <= n_out_hole;
        r_out_left    <= n_out_left;
        r_out_used    <= n_out_used;
        r_out_largest <= n_out_largest;
        r_out_failed  <= n_out_failed;
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.chosen_hole  = r_out_hole;
    assign o_rsp.hole_left    = r_out_left;
    assign o_rsp.hole_used    = r_out_used;
    assign o_rsp.largest_left = r_out_largest;
    assign o_rsp.run_failed   = r_out_failed;

endmodule
